>>> rtl/uf2pe_pkg.sv
// Package for the UF2 payload extractor: result record, status codes,
// header offsets, magic words and default sizes. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package uf2pe_pkg;

   // Default geometry of one UF2 block
   localparam int BLOCK_BYTES_DEF   = 512;
   localparam int PAYLOAD_LIMIT_DEF = 476;
   localparam int HEADER_WORDS_DEF  = 8;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Header layout: offsets of the last byte of each little-endian word
   localparam int MAGIC0_LAST_OFF = 3;
   localparam int MAGIC1_LAST_OFF = 7;
   localparam int SIZE_LAST_OFF   = 19;

   localparam logic [31:0] MAGIC_START0 = 32'h0A32_4655;
   localparam logic [31:0] MAGIC_START1 = 32'h9E5D_5157;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_LENGTH = 2'd1,
      STATUS_NO_BLOCK   = 2'd2
   } status_type;

   // One result beat as it travels from front through queue to back
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       finished;
      status_type status;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/uf2pe_req_if.sv
// Input channel of the UF2 payload extractor: one file byte per beat.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface uf2pe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_file;

   modport source (output valid, output in_byte, output end_of_file, input ready);
   modport sink   (input valid, input in_byte, input end_of_file, output ready);
endinterface

`default_nettype wire

>>> rtl/uf2pe_rsp_if.sv
// Result channel of the UF2 payload extractor: payload bytes and final status.
// Depends on uf2pe_pkg for the status type.
`timescale 1ns / 1ps
`default_nettype none

interface uf2pe_rsp_if;
   logic                 valid;
   logic                 ready;
   logic [7:0]           out_byte;
   logic                 byte_valid;
   logic                 finished;
   uf2pe_pkg::status_type status;

   modport source (output valid, output out_byte, output byte_valid,
                   output finished, output status, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input finished, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/uf2pe_front.sv
// Front of the UF2 payload extractor: accepts file bytes, tracks the block
// header and classifies each byte. Depends on uf2pe_pkg and uf2pe_req_if.
`timescale 1ns / 1ps
`default_nettype none

module uf2pe_front #(
   parameter int BLOCK_BYTES   = uf2pe_pkg::BLOCK_BYTES_DEF,
   parameter int PAYLOAD_LIMIT = uf2pe_pkg::PAYLOAD_LIMIT_DEF,
   parameter int HEADER_WORDS  = uf2pe_pkg::HEADER_WORDS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   uf2pe_req_if.sink             req,
   input  wire logic             queue_full,
   output logic                  push,
   output uf2pe_pkg::result_type push_data
);

   localparam int OFF_W = $clog2(BLOCK_BYTES);
   localparam int START = HEADER_WORDS * 4;
   localparam int END_W = $clog2(START + PAYLOAD_LIMIT + 1);
   localparam int CMP_W = (OFF_W > END_W) ? OFF_W : END_W;
   localparam logic [OFF_W-1:0] LAST_OFF = OFF_W'(BLOCK_BYTES - 1);

   logic [OFF_W-1:0] offset_ff, offset_in, offset_next;
   logic [23:0]      hist_ff, hist_in;
   logic             magic_ok_ff, magic_ok_in;
   logic             block_good_ff, block_good_in;
   logic [END_W-1:0] pay_end_ff, pay_end_in;
   logic             seen_ff, seen_in;

   logic        accept;
   logic [31:0] word;
   logic        size_hit;
   logic        byte_hit;
   logic        seen_now;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   // Newest byte on top, as the header words are little-endian
   assign word = {req.in_byte, hist_ff};

   assign offset_next = (offset_ff == LAST_OFF) ? '0 : offset_ff + OFF_W'(1);

   assign size_hit = (offset_ff == OFF_W'(uf2pe_pkg::SIZE_LAST_OFF)) && magic_ok_ff &&
                     (word <= 32'(PAYLOAD_LIMIT));

   assign byte_hit = block_good_ff &&
                     (CMP_W'(offset_ff) >= CMP_W'(START)) &&
                     (CMP_W'(offset_ff) <  CMP_W'(pay_end_ff));

   assign seen_now = seen_ff || size_hit;

   always_comb begin
      offset_in     = offset_ff;
      hist_in       = hist_ff;
      magic_ok_in   = magic_ok_ff;
      block_good_in = block_good_ff;
      pay_end_in    = pay_end_ff;
      seen_in       = seen_ff;

      push_data.out_byte   = byte_hit ? req.in_byte : 8'd0;
      push_data.byte_valid = byte_hit;
      push_data.finished   = req.end_of_file;
      push_data.status     = uf2pe_pkg::STATUS_OK;
      if (req.end_of_file) begin
         if (offset_next != '0) begin
            push_data.status = uf2pe_pkg::STATUS_BAD_LENGTH;
         end else if (!seen_now) begin
            push_data.status = uf2pe_pkg::STATUS_NO_BLOCK;
         end
      end
      push = accept && (byte_hit || req.end_of_file);

      if (accept) begin
         hist_in   = word[31:8];
         offset_in = offset_next;
         if (offset_ff == '0) begin
            block_good_in = 1'b0;
         end
         if (offset_ff == OFF_W'(uf2pe_pkg::MAGIC0_LAST_OFF)) begin
            magic_ok_in = (word == uf2pe_pkg::MAGIC_START0);
         end
         if (offset_ff == OFF_W'(uf2pe_pkg::MAGIC1_LAST_OFF)) begin
            magic_ok_in = magic_ok_ff && (word == uf2pe_pkg::MAGIC_START1);
         end
         if (size_hit) begin
            block_good_in = 1'b1;
            pay_end_in    = END_W'(START) + word[END_W-1:0];
            seen_in       = 1'b1;
         end
         // Final byte: start over for the next file
         if (req.end_of_file) begin
            offset_in     = '0;
            magic_ok_in   = 1'b0;
            block_good_in = 1'b0;
            seen_in       = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff     <= '0;
         magic_ok_ff   <= 1'b0;
         block_good_ff <= 1'b0;
         seen_ff       <= 1'b0;
      end else begin
         offset_ff     <= offset_in;
         magic_ok_ff   <= magic_ok_in;
         block_good_ff <= block_good_in;
         seen_ff       <= seen_in;
      end
   end

   always_ff @(posedge clock) begin
      hist_ff    <= hist_in;
      pay_end_ff <= pay_end_in;
   end

endmodule

`default_nettype wire

>>> rtl/uf2pe_fifo.sv
// Short result queue between front and back of the UF2 payload extractor.
// Depends on uf2pe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module uf2pe_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire uf2pe_pkg::result_type push_data,
   output logic                       full,
   input  wire logic                  pop,
   output logic                       head_valid,
   output uf2pe_pkg::result_type      head_data
);

   localparam int DEPTH = uf2pe_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   uf2pe_pkg::result_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/uf2pe_back.sv
// Back of the UF2 payload extractor: drains the queue into the output
// register that drives the result channel. Depends on uf2pe_pkg, uf2pe_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module uf2pe_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  head_valid,
   input  wire uf2pe_pkg::result_type head_data,
   output logic                       pop,
   uf2pe_rsp_if.source                rsp
);

   logic                  rsp_valid_ff, rsp_valid_in;
   uf2pe_pkg::result_type rsp_data_ff, rsp_data_in;
   logic                  load;

   // Refill the output register when it is empty or being drained
   assign load = !rsp_valid_ff || rsp.ready;
   assign pop  = head_valid && load;

   always_comb begin
      rsp_valid_in = load ? head_valid : rsp_valid_ff;
      rsp_data_in  = pop ? head_data : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = rsp_data_ff.out_byte;
   assign rsp.byte_valid = rsp_data_ff.byte_valid;
   assign rsp.finished   = rsp_data_ff.finished;
   assign rsp.status     = rsp_data_ff.status;

endmodule

`default_nettype wire

>>> rtl/uf2_payload_extractor.sv
// UF2 payload extractor, top level: front, result queue and back.
// Depends on uf2pe_pkg, uf2pe_req_if, uf2pe_rsp_if and the uf2pe_* modules.
//
// Usage:
//   req_bus carries the UF2 file one byte per beat; end_of_file marks the
//   last byte. rsp_bus carries one beat per payload byte of each valid block
//   (byte_valid = 1) and one beat for the last file byte (finished = 1) with
//   status: OK, BAD_LENGTH (file not a whole number of blocks) or NO_BLOCK.
//   Both may sit on one beat. Bytes without a result produce no beat.
//   Payload bytes go out before the status is known; drop the stream when
//   the final status is not OK.
// Timing:
//   One byte per cycle sustained while the queue is not full. A result beat
//   is written into the queue by the edge that accepts its byte, and moves
//   from there into the output register.
//   When the receiver stalls, hold the output beat; the two-entry queue
//   keeps taking results and req_bus.ready drops only once the queue is full.
// Reset:
//   Synchronous reset empties queue and output register and starts a new
//   file. After each final byte the header tracking returns to its reset
//   state as well, so the next byte begins a new file.
`timescale 1ns / 1ps
`default_nettype none

module uf2_payload_extractor #(
   parameter int BLOCK_BYTES   = uf2pe_pkg::BLOCK_BYTES_DEF,
   parameter int PAYLOAD_LIMIT = uf2pe_pkg::PAYLOAD_LIMIT_DEF,
   parameter int HEADER_WORDS  = uf2pe_pkg::HEADER_WORDS_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   uf2pe_req_if.sink   req_bus,
   uf2pe_rsp_if.source rsp_bus
);

   logic                  queue_full;
   logic                  push;
   uf2pe_pkg::result_type push_data;
   logic                  pop;
   logic                  head_valid;
   uf2pe_pkg::result_type head_data;

   // Front: track block offset and header, classify every byte
   uf2pe_front #(
      .BLOCK_BYTES   (BLOCK_BYTES),
      .PAYLOAD_LIMIT (PAYLOAD_LIMIT),
      .HEADER_WORDS  (HEADER_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // Queue: decouple byte intake from result delivery
   uf2pe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // Back: present queued beats on the result channel
   uf2pe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

   // Every beat carries a payload byte, a final status, or both
   a_beat_not_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.byte_valid || rsp_bus.finished))
      else $error("result beat carries neither byte nor status");

   // Status stays OK on beats that do not end the file
   a_status_only_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.finished) |-> (rsp_bus.status == uf2pe_pkg::STATUS_OK))
      else $error("status set on a non-final beat");

   // Unused byte field reads zero
   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.byte_valid) |-> (rsp_bus.out_byte == 8'd0))
      else $error("out_byte nonzero without byte_valid");

   // Reset leaves no stale beat on the result channel
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_bus.valid)
      else $error("result valid right after reset");

endmodule

`default_nettype wire

>>> verif/uf2pe_payload_check.sv
// Payload checker for the UF2 payload extractor: predicts result beats from
// accepted file bytes and compares them with the result channel.
// Depends on uf2pe_pkg, uf2pe_req_if and uf2pe_rsp_if.
`timescale 1ns / 1ps
`default_nettype none

module uf2pe_payload_check #(
   parameter int BLOCK_BYTES   = uf2pe_pkg::BLOCK_BYTES_DEF,
   parameter int PAYLOAD_LIMIT = uf2pe_pkg::PAYLOAD_LIMIT_DEF,
   parameter int HEADER_WORDS  = uf2pe_pkg::HEADER_WORDS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   uf2pe_req_if      req_mon,
   uf2pe_rsp_if      rsp_mon,
   output int        fail_count,
   output int        outstanding
);

   localparam int OFFSET_W      = $clog2(BLOCK_BYTES);
   localparam int LENGTH_W      = $clog2(PAYLOAD_LIMIT + 1);
   localparam int PAYLOAD_START = HEADER_WORDS * 4;

   // Header tracking of the file in flight
   logic [OFFSET_W-1:0] blk_pos;
   logic [31:0]         recent_bytes;
   logic                magic_match;
   logic [LENGTH_W-1:0] payload_len;
   logic                hdr_accepted;
   logic                any_block_ok;

   uf2pe_pkg::result_type expected_beats[$];

   task automatic clear_file_state();
      blk_pos      = '0;
      recent_bytes = '0;
      magic_match  = 1'b0;
      payload_len  = '0;
      hdr_accepted = 1'b0;
      any_block_ok = 1'b0;
   endtask

   task automatic predict_byte(input logic [7:0] data, input logic last);
      logic                  pass_byte;
      int                    next_pos;
      uf2pe_pkg::status_type file_status;
      uf2pe_pkg::result_type beat;
      if (blk_pos == 0) begin
         magic_match  = 1'b0;
         hdr_accepted = 1'b0;
         payload_len  = '0;
      end
      recent_bytes = {data, recent_bytes[31:8]};
      if (blk_pos == uf2pe_pkg::MAGIC0_LAST_OFF)
         magic_match = (recent_bytes == uf2pe_pkg::MAGIC_START0);
      if (blk_pos == uf2pe_pkg::MAGIC1_LAST_OFF)
         magic_match = magic_match && (recent_bytes == uf2pe_pkg::MAGIC_START1);
      if (blk_pos == uf2pe_pkg::SIZE_LAST_OFF && magic_match
          && recent_bytes <= PAYLOAD_LIMIT) begin
         hdr_accepted = 1'b1;
         payload_len  = recent_bytes[LENGTH_W-1:0];
         any_block_ok = 1'b1;
      end
      pass_byte = hdr_accepted && int'(blk_pos) >= PAYLOAD_START
                  && int'(blk_pos) - PAYLOAD_START < int'(payload_len);
      next_pos = int'(blk_pos) + 1;
      if (next_pos >= BLOCK_BYTES)
         next_pos = 0;
      blk_pos = OFFSET_W'(next_pos);

      file_status = uf2pe_pkg::STATUS_OK;
      if (last) begin
         if (next_pos != 0)
            file_status = uf2pe_pkg::STATUS_BAD_LENGTH;
         else if (!any_block_ok)
            file_status = uf2pe_pkg::STATUS_NO_BLOCK;
         clear_file_state();
      end
      if (pass_byte || last) begin
         beat.out_byte   = pass_byte ? data : 8'h00;
         beat.byte_valid = pass_byte;
         beat.finished   = last;
         beat.status     = file_status;
         expected_beats.insert(expected_beats.size(), beat);
      end
   endtask

   task automatic check_beat();
      uf2pe_pkg::result_type want;
      if (expected_beats.size() == 0) begin
         $error("unexpected result beat: out_byte %0d byte_valid %0b finished %0b status %0d",
                rsp_mon.out_byte, rsp_mon.byte_valid, rsp_mon.finished, rsp_mon.status);
         fail_count++;
         return;
      end
      want = expected_beats.pop_front();
      if (rsp_mon.out_byte !== want.out_byte) begin
         $error("out_byte mismatch: expected %0d, actual %0d", want.out_byte, rsp_mon.out_byte);
         fail_count++;
      end
      if (rsp_mon.byte_valid !== want.byte_valid) begin
         $error("byte_valid mismatch: expected %0b, actual %0b",
                want.byte_valid, rsp_mon.byte_valid);
         fail_count++;
      end
      if (rsp_mon.finished !== want.finished) begin
         $error("finished mismatch: expected %0b, actual %0b", want.finished, rsp_mon.finished);
         fail_count++;
      end
      if (rsp_mon.status !== want.status) begin
         $error("status mismatch: expected %0d, actual %0d", want.status, rsp_mon.status);
         fail_count++;
      end
   endtask

   // Compare before predicting: a beat leaving now never belongs to the byte
   // entering on the same edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_file_state();
         expected_beats.delete();
         fail_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready)
            check_beat();
         if (req_mon.valid && req_mon.ready)
            predict_byte(req_mon.in_byte, req_mon.end_of_file);
      end
      outstanding = expected_beats.size();
   end

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Testbench top for the UF2 payload extractor: clock, reset, file stimulus,
// result-side stalls and verdict. Depends on uf2pe_pkg, both channel
// interfaces, uf2_payload_extractor and uf2pe_payload_check.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

   localparam int ITEM_TARGET    = 1650;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = 8;
   localparam int PAYLOAD_START  = uf2pe_pkg::HEADER_WORDS_DEF * 4;
   localparam int SHORT_SIZE_CAP = 40;
   // How far a whole-block file may run past the end of its phase
   localparam int FIT_SLACK      = uf2pe_pkg::BLOCK_BYTES_DEF / 2;

   // Shape of the header written into one block of a generated file
   typedef enum int {
      HDR_GOOD,
      HDR_BAD_MAGIC0,
      HDR_BAD_MAGIC1,
      HDR_OVERSIZE,
      HDR_NOISE
   } header_kind_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   outstanding;
   int   cycle_count = 0;
   int   items_sent  = 0;
   int   req_idle_pct;
   int   rsp_stall_pct;

   // Bytes of the file about to be streamed in
   logic [7:0] file_img[$];

   uf2pe_req_if req_bus ();
   uf2pe_rsp_if rsp_bus ();

   uf2_payload_extractor uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   uf2pe_payload_check payload_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Stall the result side at random; a zero rate keeps ready high throughout.
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Hard stop: a hung handshake or a lost beat ends up here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Zero and the limit itself come up often; the rest stays within the cap, so
   // that short files end inside or just past their payload.
   function automatic logic [31:0] pick_size(input header_kind_type kind,
                                             input int unsigned cap);
      int unsigned roll;
      if (kind == HDR_OVERSIZE) begin
         if ($urandom_range(1) == 0)
            return 32'(uf2pe_pkg::PAYLOAD_LIMIT_DEF + 1);
         return $urandom_range(32'hFFFF_FFFF, uf2pe_pkg::PAYLOAD_LIMIT_DEF + 2);
      end
      roll = $urandom_range(7);
      if (roll == 0)
         return 32'd0;
      if (roll == 1)
         return 32'(uf2pe_pkg::PAYLOAD_LIMIT_DEF);
      return $urandom_range(cap, 1);
   endfunction

   function automatic header_kind_type pick_kind();
      if ($urandom_range(9) < 6)
         return HDR_GOOD;
      return header_kind_type'($urandom_range(HDR_NOISE, HDR_BAD_MAGIC0));
   endfunction

   // Append nbytes of one block; header fields land at their offsets unless
   // the block is pure noise, everything else is random.
   task automatic add_block(input header_kind_type kind, input int nbytes,
                            input logic [31:0] size_word);
      logic [31:0] magic0;
      logic [31:0] magic1;
      logic [7:0]  data;
      magic0 = uf2pe_pkg::MAGIC_START0;
      magic1 = uf2pe_pkg::MAGIC_START1;
      if (kind == HDR_BAD_MAGIC0)
         magic0 = magic0 ^ (32'd1 << $urandom_range(31));
      if (kind == HDR_BAD_MAGIC1)
         magic1 = magic1 ^ (32'd1 << $urandom_range(31));
      for (int i = 0; i < nbytes; i++) begin
         data = 8'($urandom_range(255));
         if (kind != HDR_NOISE) begin
            if (i <= uf2pe_pkg::MAGIC0_LAST_OFF)
               data = magic0[8*i +: 8];
            else if (i <= uf2pe_pkg::MAGIC1_LAST_OFF)
               data = magic1[8*(i - uf2pe_pkg::MAGIC0_LAST_OFF - 1) +: 8];
            else if (i > uf2pe_pkg::SIZE_LAST_OFF - 4 && i <= uf2pe_pkg::SIZE_LAST_OFF)
               data = size_word[8*(i - uf2pe_pkg::SIZE_LAST_OFF + 3) +: 8];
         end
         file_img.insert(file_img.size(), data);
      end
   endtask

   // Short file: cut somewhere in the header or the payload.
   task automatic add_short_file();
      header_kind_type kind;
      kind = pick_kind();
      add_block(kind, $urandom_range(PAYLOAD_START + SHORT_SIZE_CAP, 1),
                pick_size(kind, SHORT_SIZE_CAP));
   endtask

   // Present one byte, hold it until accepted, and return at the next falling
   // edge. Valid stays high across back-to-back beats.
   task automatic send_beat(input logic [7:0] data, input logic last);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.in_byte     <= data;
      req_bus.end_of_file <= last;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      items_sent++;
   endtask

   task automatic send_file();
      for (int i = 0; i < file_img.size(); i++)
         send_beat(file_img[i], i == file_img.size() - 1);
      file_img.delete();
   endtask

   // Drop valid and hold off until every predicted beat has come back.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (outstanding != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      int              files_done;
      int              full_files;
      int              phase_end;
      int unsigned     nblocks;
      header_kind_type kind;

      files_done = 0;
      full_files = 0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      req_bus.valid       = 1'b0;
      req_bus.in_byte     = 8'h00;
      req_bus.end_of_file = 1'b0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: one-byte files at both byte extremes, each a length error.
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b1);
      // A file that stops on the last size byte: the header is taken at the
      // payload limit, yet the partial block still reports a length error.
      add_block(HDR_GOOD, uf2pe_pkg::SIZE_LAST_OFF + 1, 32'(uf2pe_pkg::PAYLOAD_LIMIT_DEF));
      send_file();

      // Random files in four idle and stall phases; drain completely between phases.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin req_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin req_idle_pct = 55; rsp_stall_pct = 0;  end
            2: begin req_idle_pct = 0;  rsp_stall_pct = 55; end
            default: begin req_idle_pct = 6; rsp_stall_pct = 6; end
         endcase
         phase_end = ITEM_TARGET * (phase + 1) / 4;
         while (items_sent < phase_end) begin
            if (files_done % 3 == 1) begin
               // Whole-block file: first a clean one, then a broken one,
               // afterwards anything, sometimes two blocks long.
               if (full_files == 0)
                  kind = HDR_GOOD;
               else if (full_files == 1)
                  kind = header_kind_type'($urandom_range(HDR_NOISE, HDR_BAD_MAGIC0));
               else
                  kind = pick_kind();
               nblocks = (full_files >= 2 && $urandom_range(2) == 0) ? 2 : 1;
               add_block(kind, uf2pe_pkg::BLOCK_BYTES_DEF,
                         pick_size(kind, uf2pe_pkg::PAYLOAD_LIMIT_DEF));
               if (nblocks == 2) begin
                  kind = pick_kind();
                  add_block(kind, uf2pe_pkg::BLOCK_BYTES_DEF,
                            pick_size(kind, uf2pe_pkg::PAYLOAD_LIMIT_DEF));
               end
               // A stray tail turns the status into a length error even
               // after good blocks.
               if (full_files >= 2 && $urandom_range(3) == 0) begin
                  kind = pick_kind();
                  add_block(kind, $urandom_range(SHORT_SIZE_CAP, 1),
                            pick_size(kind, SHORT_SIZE_CAP));
               end
               // Keep the item total near target: swap in a short file when
               // the whole-block one would run far past the phase end.
               if (items_sent + file_img.size() > phase_end + FIT_SLACK) begin
                  file_img.delete();
                  add_short_file();
               end else begin
                  full_files++;
               end
            end else begin
               add_short_file();
            end
            send_file();
            files_done++;
         end
         drain_results();
      end

      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

`default_nettype wire
